// ----- hdl/tms_pkg.sv -----
// ----------------------------------------------------------------------------
// Turing machine stepper package
// Widths, capacities, command, move, status and register codes, and the
// layout of one transition table entry.
// ----------------------------------------------------------------------------
package tms_pkg;

  localparam int STATE_COUNT = 16;
  localparam int TABLE_DEPTH = 64;
  localparam int TAPE_DEPTH  = 1024;

  localparam int STATE_W  = $clog2(STATE_COUNT);
  localparam int SYM_W    = 8;
  localparam int MOVE_W   = 2;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int TABLE_AW = $clog2(TABLE_DEPTH);
  localparam int TAPE_AW  = $clog2(TAPE_DEPTH);
  localparam int LEN_W    = TAPE_AW + 1;
  localparam int CNT_W    = TABLE_AW + 1;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 8;

  localparam logic [LEN_W-1:0] TAPE_CAP  = LEN_W'(TAPE_DEPTH);
  localparam logic [CNT_W-1:0] TABLE_CAP = CNT_W'(TABLE_DEPTH);

  // Commands carried by an input item
  localparam logic [CMD_W-1:0] CMD_WRITE_ENTRY = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BEGIN       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STEP        = 3'd4;

  // Head moves
  localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd0;
  localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd1;

  // Run status
  localparam logic [STATUS_W-1:0] ST_IDLE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RUN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ACC  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REJ  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_START_STATE  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_ACCEPT_STATE = 2'd1;
  localparam logic [CFG_AW-1:0] REG_BLANK_SYMBOL = 2'd2;
  localparam logic [CFG_AW-1:0] REG_ENTRY_COUNT  = 2'd3;

  typedef struct packed {
    logic [STATE_W-1:0] match_state;
    logic [SYM_W-1:0]   match_symbol;
    logic [STATE_W-1:0] next_state;
    logic [SYM_W-1:0]   write_symbol;
    logic [MOVE_W-1:0]  move;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- hdl/turing_machine_stepper_core.sv -----
// ----------------------------------------------------------------------------
// Turing machine stepper core
// Single-tape machine with its tape and transition table held in RAM.
// ----------------------------------------------------------------------------
// Usage: every item on the input channel (in_valid/in_ready) carries one
// command: write a table entry, append a tape symbol, clear the tape, begin
// a run, or take one step. Each item yields exactly one result item on the
// output channel (out_valid/out_ready) showing the machine state, head
// position, symbol under the head, tape length, run status and overflow.
// The block works on one item at a time. A write, append, clear, begin or
// a step that cannot run goes through S_READ and S_OUT after acceptance.
// A step first searches the table RAM in order, one read per cycle, until an
// entry matches or the entries run out; a right move that grows the tape
// adds S_GROW; then the step too goes through S_READ and S_OUT.
// The result sits in an output register, so the next item is taken while a
// result still waits; if the receiver stalls, the block finishes its item
// and then holds until the result register frees.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wr_data while the
// block is idle. A synchronous reset returns the registers to their defaults
// and the machine to idle with an empty tape; both RAMs keep their contents.
// No item is taken while rst is high.
// ----------------------------------------------------------------------------
module turing_machine_stepper_core (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [tms_pkg::CFG_AW-1:0]     cfg_index,
  input  logic [tms_pkg::CFG_DW-1:0]     cfg_wr_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tms_pkg::CMD_W-1:0]      cmd,
  input  logic [tms_pkg::TABLE_AW-1:0]   entry_index,
  input  logic [tms_pkg::STATE_W-1:0]    entry_state,
  input  logic [tms_pkg::SYM_W-1:0]      entry_symbol,
  input  logic [tms_pkg::STATE_W-1:0]    entry_next_state,
  input  logic [tms_pkg::SYM_W-1:0]      entry_write,
  input  logic [tms_pkg::MOVE_W-1:0]     entry_move,
  input  logic [tms_pkg::SYM_W-1:0]      tape_symbol,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tms_pkg::STATE_W-1:0]    machine_state,
  output logic [tms_pkg::TAPE_AW-1:0]    head_position,
  output logic [tms_pkg::SYM_W-1:0]      head_symbol,
  output logic [tms_pkg::LEN_W-1:0]      tape_used,
  output logic [tms_pkg::STATUS_W-1:0]   run_status,
  output logic                           tape_overflow
);

  import tms_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for an item
  localparam logic [2:0] S_SEARCH = 3'd1;  // one table entry checked per cycle
  localparam logic [2:0] S_GROW   = 3'd2;  // append a blank after a right move
  localparam logic [2:0] S_READ   = 3'd3;  // read the cell under the head
  localparam logic [2:0] S_OUT    = 3'd4;  // load the result register

  logic [2:0] fsm;

  // Configuration registers
  logic [STATE_W-1:0] start_state;
  logic [STATE_W-1:0] accept_state;
  logic [SYM_W-1:0]   blank_symbol;
  logic [CNT_W-1:0]   entry_count;

  // Machine registers
  logic [STATE_W-1:0]  current_state;
  logic [TAPE_AW-1:0]  head;
  logic [LEN_W-1:0]    tape_length;
  logic [STATUS_W-1:0] status;
  logic                overflow_flag;
  logic [TABLE_AW-1:0] search_idx;

  // RAM ports
  logic                tape_we;
  logic [TAPE_AW-1:0]  tape_waddr;
  logic [SYM_W-1:0]    tape_wdata;
  logic                tape_re;
  logic [SYM_W-1:0]    tape_rdata;
  logic                table_we;
  logic                table_re;
  logic [TABLE_AW-1:0] table_raddr;
  logic [ENTRY_W-1:0]  table_rdata;
  entry_t              wr_entry;
  entry_t              rd_entry;

  logic             in_fire;
  logic             can_step;
  logic             hit;
  logic             last_entry;
  logic             at_end;
  logic [CNT_W-1:0] limit;

  assign in_ready = (fsm == S_IDLE) && !rst;
  assign in_fire  = in_valid && in_ready;

  // The search covers the slots below entry_count, never beyond the table.
  assign limit      = (entry_count > TABLE_CAP) ? TABLE_CAP : entry_count;
  assign can_step   = (status == ST_RUN) && ({1'b0, head} < tape_length);
  assign rd_entry   = entry_t'(table_rdata);
  // The tape read issued with the step still holds the symbol under the head.
  assign hit        = (rd_entry.match_state == current_state) &&
                      (rd_entry.match_symbol == tape_rdata);
  assign last_entry = ({1'b0, search_idx} + CNT_W'(1)) >= limit;
  assign at_end     = ({1'b0, head} + LEN_W'(1)) >= tape_length;

  assign wr_entry = '{match_state:  entry_state,
                      match_symbol: entry_symbol,
                      next_state:   entry_next_state,
                      write_symbol: entry_write,
                      move:         entry_move};

  // Table RAM: written directly by a write entry item; read from slot 0 when
  // any item is accepted, then one slot ahead of the compare in each cycle.
  assign table_we    = in_fire && (cmd == CMD_WRITE_ENTRY);
  assign table_re    = in_fire || (fsm == S_SEARCH);
  assign table_raddr = (fsm == S_SEARCH) ? (search_idx + TABLE_AW'(1)) : '0;

  // Tape RAM reads only ever look under the head.
  assign tape_re = (fsm == S_READ) || (in_fire && (cmd == CMD_STEP));

  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = head;
    tape_wdata = blank_symbol;
    if (in_fire) begin
      unique case (cmd)
        CMD_APPEND: begin
          tape_we    = (tape_length < TAPE_CAP);
          tape_waddr = tape_length[TAPE_AW-1:0];
          tape_wdata = tape_symbol;
        end
        CMD_BEGIN: begin
          tape_we    = (tape_length == '0);
          tape_waddr = '0;
          tape_wdata = blank_symbol;
        end
        default: begin
        end
      endcase
    end else if ((fsm == S_SEARCH) && hit) begin
      tape_we    = 1'b1;
      tape_waddr = head;
      tape_wdata = rd_entry.write_symbol;
    end else if (fsm == S_GROW) begin
      tape_we    = 1'b1;
      tape_waddr = tape_length[TAPE_AW-1:0];
      tape_wdata = blank_symbol;
    end
  end

  tms_ram #(
    .WIDTH (SYM_W),
    .DEPTH (TAPE_DEPTH)
  ) u_tape_ram (
    .clk     (clk),
    .wr_en   (tape_we),
    .wr_addr (tape_waddr),
    .wr_data (tape_wdata),
    .rd_en   (tape_re),
    .rd_addr (head),
    .rd_data (tape_rdata)
  );

  tms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table_ram (
    .clk     (clk),
    .wr_en   (table_we),
    .wr_addr (entry_index),
    .wr_data (wr_entry),
    .rd_en   (table_re),
    .rd_addr (table_raddr),
    .rd_data (table_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm           <= S_IDLE;
      start_state   <= '0;
      accept_state  <= STATE_W'(1);
      blank_symbol  <= SYM_W'(95);
      entry_count   <= '0;
      current_state <= '0;
      head          <= '0;
      tape_length   <= '0;
      status        <= ST_IDLE;
      overflow_flag <= 1'b0;
      search_idx    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_START_STATE:  start_state  <= cfg_wr_data[STATE_W-1:0];
          REG_ACCEPT_STATE: accept_state <= cfg_wr_data[STATE_W-1:0];
          REG_BLANK_SYMBOL: blank_symbol <= cfg_wr_data[SYM_W-1:0];
          REG_ENTRY_COUNT:  entry_count  <= cfg_wr_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end

      if ((fsm == S_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (fsm)
        S_IDLE: begin
          if (in_fire) begin
            search_idx <= '0;
            // With an empty table the step rejects at once and skips the
            // search.
            fsm <= ((cmd == CMD_STEP) && can_step && (limit != '0)) ?
                   S_SEARCH : S_READ;
            unique case (cmd)
              CMD_APPEND: begin
                // A full tape drops the symbol.
                if (tape_length < TAPE_CAP) begin
                  tape_length <= tape_length + LEN_W'(1);
                end
              end
              CMD_CLEAR: begin
                tape_length   <= '0;
                head          <= '0;
                status        <= ST_IDLE;
                overflow_flag <= 1'b0;
              end
              CMD_BEGIN: begin
                head          <= '0;
                current_state <= start_state;
                overflow_flag <= 1'b0;
                if (tape_length == '0) begin
                  tape_length <= LEN_W'(1);
                end
                status <= (start_state == accept_state) ? ST_ACC : ST_RUN;
              end
              CMD_STEP: begin
                if (can_step && (limit == '0)) begin
                  status <= ST_REJ;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SEARCH: begin
          if (hit) begin
            current_state <= rd_entry.next_state;
            if ((rd_entry.move == MOVE_RIGHT) && at_end && (tape_length < TAPE_CAP)) begin
              // The new blank cell is written in the next cycle, and the
              // accept state is checked there.
              fsm <= S_GROW;
            end else begin
              fsm <= S_READ;
              if ((rd_entry.move == MOVE_RIGHT) && at_end) begin
                // Overflow rejects even when the accept state was reached.
                overflow_flag <= 1'b1;
                status        <= ST_REJ;
              end else begin
                if (rd_entry.next_state == accept_state) begin
                  status <= ST_ACC;
                end
                if ((rd_entry.move == MOVE_LEFT) && (head != '0)) begin
                  head <= head - TAPE_AW'(1);
                end else if (rd_entry.move == MOVE_RIGHT) begin
                  head <= head + TAPE_AW'(1);
                end
              end
            end
          end else if (last_entry) begin
            status <= ST_REJ;
            fsm    <= S_READ;
          end else begin
            search_idx <= search_idx + TABLE_AW'(1);
          end
        end

        S_GROW: begin
          tape_length <= tape_length + LEN_W'(1);
          head        <= head + TAPE_AW'(1);
          if (current_state == accept_state) begin
            status <= ST_ACC;
          end
          fsm <= S_READ;
        end

        S_READ: begin
          fsm <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid || out_ready) begin
            fsm <= S_IDLE;
          end
        end

        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

  // Result register: loaded as the sequencer leaves S_OUT. An empty tape
  // shows the blank symbol under the head.
  always_ff @(posedge clk) begin
    if ((fsm == S_OUT) && (!out_valid || out_ready)) begin
      machine_state <= current_state;
      head_position <= head;
      head_symbol   <= (tape_length == '0) ? blank_symbol : tape_rdata;
      tape_used     <= tape_length;
      run_status    <= status;
      tape_overflow <= overflow_flag;
    end
  end

endmodule

// ----- hdl/tms_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/tms_checker.sv -----
// ----------------------------------------------------------------------------
// Turing machine stepper port checker
// Watches the ports of the core and checks handshake and result consistency.
// ----------------------------------------------------------------------------
module tms_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tms_pkg::STATE_W-1:0]  machine_state,
  input logic [tms_pkg::TAPE_AW-1:0]  head_position,
  input logic [tms_pkg::SYM_W-1:0]    head_symbol,
  input logic [tms_pkg::LEN_W-1:0]    tape_used,
  input logic [tms_pkg::STATUS_W-1:0] run_status,
  input logic                         tape_overflow
);

  import tms_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(machine_state) && $stable(head_position) &&
      $stable(head_symbol) && $stable(tape_used) && $stable(run_status) &&
      $stable(tape_overflow))
    else $error("result payload changed while stalled");

  // The tape never grows past its capacity.
  a_tape_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tape_used <= TAPE_CAP)
    else $error("tape length beyond capacity");

  // While running, the head always sits on a used cell.
  a_head_on_tape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (run_status == ST_RUN) |-> {1'b0, head_position} < tape_used)
    else $error("running with the head off the tape");

  // Overflow only ever comes with a rejected run.
  a_overflow_rej: assert property (@(posedge clk) disable iff (rst)
    out_valid && tape_overflow |-> run_status == ST_REJ)
    else $error("overflow reported without rejection");

endmodule

bind turing_machine_stepper_core tms_checker u_tms_checker (.*);
